>>> src/tpm_pkg.sv
// Package for the trie prefix matcher: sizes, status codes, request and result
// structs, and the character-to-symbol map.
// No dependencies.
package tpm_pkg;

  // Node table sizing
  localparam int NodeCapacity = 1024;
  localparam int AlphabetSize = 37;
  localparam int NodeW        = $clog2(NodeCapacity);
  localparam int UsedW        = NodeW + 1;
  localparam int ChildDepth   = NodeCapacity * AlphabetSize;
  localparam int ChildAw      = $clog2(ChildDepth);

  // Field widths
  localparam int SymW   = 6;
  localparam int DepthW = 10;
  localparam int RuleW  = 16;
  localparam int CharW  = 8;

  localparam logic [DepthW-1:0] DepthMax = '1;
  localparam logic [RuleW-1:0]  RuleMax  = '1;

  // Character codes and symbol values
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharLowA  = 8'h61;
  localparam logic [CharW-1:0] CharLowZ  = 8'h7a;
  localparam logic [CharW-1:0] CharDot   = 8'h2e;
  localparam logic [SymW-1:0]  SymLetter = 6'd10;
  localparam logic [SymW-1:0]  SymDot    = 6'd36;

  typedef enum logic [2:0] {
    StMatch    = 3'd0,
    StNoMatch  = 3'd1,
    StBadChar  = 3'd2,
    StFull     = 3'd3,
    StInserted = 3'd4
  } status_e;

  typedef struct packed {
    logic               we;
    logic [ChildAw-1:0] addr;
    logic [NodeW-1:0]   wdata;
  } child_req_t;

  typedef struct packed {
    logic             we;
    logic [NodeW-1:0] addr;
    logic             wdata;
  } mark_req_t;

  typedef struct packed {
    status_e           status;
    logic [DepthW-1:0] match_length;
    logic [RuleW-1:0]  rule_count;
  } res_t;

  // Map a raw byte to {supported, symbol}
  function automatic logic [SymW:0] symbol_of(logic [CharW-1:0] c);
    logic [SymW:0] r;
    r = '0;
    if (c >= CharZero && c <= CharNine) begin
      r = {1'b1, SymW'(c - CharZero)};
    end else if (c >= CharLowA && c <= CharLowZ) begin
      r = {1'b1, SymW'(c - CharLowA) + SymLetter};
    end else if (c == CharDot) begin
      r = {1'b1, SymDot};
    end
    return r;
  endfunction

endpackage

>>> src/tpm_in_if.sv
// Input channel of the trie prefix matcher: one character beat per item.
// Depends on tpm_pkg for field widths.
interface tpm_in_if
  import tpm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [CharW-1:0] ch;
  logic             has_char;
  logic             last_char;

  modport source (output valid, cmd, ch, has_char, last_char, input ready);
  modport sink   (input valid, cmd, ch, has_char, last_char, output ready);
endinterface

>>> src/tpm_out_if.sv
// Result channel of the trie prefix matcher: one beat per string.
// Depends on tpm_pkg for field widths.
interface tpm_out_if
  import tpm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [DepthW-1:0] match_length;
  logic [RuleW-1:0]  rule_count;

  modport source (output valid, status, match_length, rule_count, input ready);
  modport sink   (input valid, status, match_length, rule_count, output ready);
endinterface

>>> src/tpm_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module tpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tpm_walk.sv
// Trie walker: sequencer that reads, allocates and marks trie nodes in the
// child and end-mark memories. Depends on tpm_pkg and tpm_in_if.
module tpm_walk
  import tpm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  tpm_in_if.sink           in_i,
  output child_req_t       child_req_o,
  input  logic [NodeW-1:0] child_rdata_i,
  output mark_req_t        mark_req_o,
  input  logic             mark_rdata_i,
  input  logic             slot_free_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  typedef enum logic [4:0] {
    SClear  = 5'b00001,
    SIdle   = 5'b00010,
    SLook   = 5'b00100,
    SMark   = 5'b01000,
    SFinish = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [ChildAw-1:0] clr_q, clr_d;
  logic [ChildAw-1:0] slot_q, slot_d;
  logic [NodeW-1:0]   cur_q, cur_d;
  logic [DepthW-1:0]  depth_q, depth_d;
  logic               decided_q, decided_d;
  status_e            pend_q, pend_d;
  logic [UsedW-1:0]   used_q, used_d;
  logic [RuleW-1:0]   rules_q, rules_d;
  logic               cur_mark_q, cur_mark_d;
  logic               root_mark_q, root_mark_d;
  logic               cmd_q, cmd_d;
  logic               last_q, last_d;

  assign in_i.ready = (state_q == SIdle);

  // Step through one item
  always_comb begin
    logic          dec;
    status_e       pend;
    logic [SymW:0] sym_r;
    status_e       fin;
    logic          ins;
    state_d     = state_q;
    clr_d       = clr_q;
    slot_d      = slot_q;
    cur_d       = cur_q;
    depth_d     = depth_q;
    decided_d   = decided_q;
    pend_d      = pend_q;
    used_d      = used_q;
    rules_d     = rules_q;
    cur_mark_d  = cur_mark_q;
    root_mark_d = root_mark_q;
    cmd_d       = cmd_q;
    last_d      = last_q;
    child_req_o = '0;
    mark_req_o  = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    dec         = decided_q;
    pend        = pend_q;
    sym_r       = symbol_of(in_i.ch);
    fin         = StMatch;
    ins         = 1'b0;

    case (state_q)
      // Zero both memories after reset
      SClear: begin
        child_req_o.we   = 1'b1;
        child_req_o.addr = clr_q;
        mark_req_o.we    = (clr_q < ChildAw'(NodeCapacity));
        mark_req_o.addr  = clr_q[NodeW-1:0];
        if (clr_q == ChildAw'(ChildDepth - 1)) begin
          state_d = SIdle;
        end else begin
          clr_d = clr_q + ChildAw'(1);
        end
      end

      // Take a beat, check the current mark and start the child lookup
      SIdle: begin
        if (in_i.valid) begin
          cmd_d  = in_i.cmd;
          last_d = in_i.last_char;
          if (!dec && in_i.cmd && cur_mark_q) begin
            dec  = 1'b1;
            pend = StMatch;
          end
          state_d = in_i.last_char ? SFinish : SIdle;
          if (!dec && in_i.has_char) begin
            if (!sym_r[SymW]) begin
              dec  = 1'b1;
              pend = StBadChar;
            end else begin
              slot_d = ChildAw'(cur_q) * ChildAw'(AlphabetSize)
                       + ChildAw'(sym_r[SymW-1:0]);
              child_req_o.addr = slot_d;
              state_d          = SLook;
            end
          end
          decided_d = dec;
          pend_d    = pend;
        end
      end

      // Follow the child or allocate a new node
      SLook: begin
        state_d = last_q ? SFinish : SIdle;
        if (child_rdata_i != '0) begin
          cur_d           = child_rdata_i;
          depth_d         = (depth_q == DepthMax) ? depth_q : depth_q + DepthW'(1);
          mark_req_o.addr = child_rdata_i;
          state_d         = SMark;
        end else if (cmd_q) begin
          decided_d = 1'b1;
          pend_d    = StNoMatch;
        end else if (used_q >= UsedW'(NodeCapacity)) begin
          decided_d = 1'b1;
          pend_d    = StFull;
        end else begin
          child_req_o.we    = 1'b1;
          child_req_o.addr  = slot_q;
          child_req_o.wdata = used_q[NodeW-1:0];
          cur_d             = used_q[NodeW-1:0];
          used_d            = used_q + UsedW'(1);
          depth_d           = (depth_q == DepthMax) ? depth_q : depth_q + DepthW'(1);
          cur_mark_d        = 1'b0;
        end
      end

      // Pick up the child node's end mark
      SMark: begin
        cur_mark_d = mark_rdata_i;
        if (cmd_q && mark_rdata_i) begin
          decided_d = 1'b1;
          pend_d    = StMatch;
        end
        state_d = last_q ? SFinish : SIdle;
      end

      // Close the string and hand over the result beat
      SFinish: begin
        if (slot_free_i) begin
          if (decided_q) begin
            fin = pend_q;
          end else if (cmd_q) begin
            fin = StNoMatch;
          end else begin
            fin = StInserted;
            ins = 1'b1;
          end
          if (ins) begin
            mark_req_o.we    = 1'b1;
            mark_req_o.addr  = cur_q;
            mark_req_o.wdata = 1'b1;
            rules_d = (rules_q == RuleMax) ? rules_q : rules_q + RuleW'(1);
            if (cur_q == '0) begin
              root_mark_d = 1'b1;
            end
          end
          res_valid_o        = 1'b1;
          res_o.status       = fin;
          res_o.match_length = (fin == StMatch) ? depth_q : '0;
          res_o.rule_count   = rules_d;
          cur_d              = '0;
          depth_d            = '0;
          decided_d          = 1'b0;
          pend_d             = StMatch;
          cur_mark_d         = root_mark_d;
          state_d            = SIdle;
        end
      end

      default: begin
        state_d = SClear;
        clr_d   = '0;
      end
    endcase
  end

  // Control and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      cur_q       <= '0;
      depth_q     <= '0;
      decided_q   <= 1'b0;
      pend_q      <= StMatch;
      used_q      <= UsedW'(1);
      rules_q     <= '0;
      cur_mark_q  <= 1'b0;
      root_mark_q <= 1'b0;
      cmd_q       <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cur_q       <= cur_d;
      depth_q     <= depth_d;
      decided_q   <= decided_d;
      pend_q      <= pend_d;
      used_q      <= used_d;
      rules_q     <= rules_d;
      cur_mark_q  <= cur_mark_d;
      root_mark_q <= root_mark_d;
      cmd_q       <= cmd_d;
      last_q      <= last_d;
    end
  end

  // Slot address of the pending lookup
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

>>> src/trie_prefix_matcher_core.sv
// Trie shortest-prefix matcher top level. After reset the child and end-mark
// memories are zeroed, with the input not ready meanwhile. A beat that needs
// no lookup (no character, unsupported character, string already decided)
// is taken in SIdle alone; a lookup adds SLook for the child read and, when it
// follows a stored child, SMark for the end-mark read; a last beat adds SFinish,
// held while the output register is held, and its result then goes into that register.
module trie_prefix_matcher_core
  import tpm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  tpm_in_if.sink   in_i,
  tpm_out_if.source out_o
);

  child_req_t       child_req;
  mark_req_t        mark_req;
  logic [NodeW-1:0] child_rdata;
  logic             mark_rdata;
  logic             res_valid;
  res_t             res;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;
  logic             slot_free;

  tpm_ram #(
    .Width (NodeW),
    .Depth (ChildDepth)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_req.we),
    .addr_i  (child_req.addr),
    .wdata_i (child_req.wdata),
    .rdata_o (child_rdata)
  );

  tpm_ram #(
    .Width (1),
    .Depth (NodeCapacity)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_req.we),
    .addr_i  (mark_req.addr),
    .wdata_i (mark_req.wdata),
    .rdata_o (mark_rdata)
  );

  tpm_walk u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .child_req_o   (child_req),
    .child_rdata_i (child_rdata),
    .mark_req_o    (mark_req),
    .mark_rdata_i  (mark_rdata),
    .slot_free_i   (slot_free),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Output register frees up when its beat is taken
  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.match_length = out_q.match_length;
  assign out_o.rule_count   = out_q.rule_count;

endmodule

>>> test/trie_prefix_matcher_core_test.sv
// Self-checking bench for trie_prefix_matcher_core: streams insert and match
// strings a character beat at a time and checks every result against a trie
// predictor. Depends on tpm_pkg, tpm_in_if, tpm_out_if and the core.
module trie_prefix_matcher_core_test
  import tpm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NoSym        = -1;
  localparam int IdlePercent  = 23;
  localparam int EndSettle    = 16;
  localparam bit CmdInsert    = 1'b0;
  localparam bit CmdMatch     = 1'b1;

  // Trie predictor with the queue of results still owed by the block
  class trie_tracker;
    logic [NodeW-1:0] kids [ChildDepth];
    bit               marks [NodeCapacity];
    int               node;
    int               depth;
    int               nodes_used;
    bit               decided;
    status_e          held_status;
    logic [RuleW-1:0] rules;
    res_t             due_results [$];
    int               faults;

    function new();
      foreach (kids[i]) kids[i] = '0;
      foreach (marks[i]) marks[i] = 1'b0;
      node        = 0;
      depth       = 0;
      nodes_used  = 1;
      decided     = 1'b0;
      held_status = StMatch;
      rules       = '0;
      faults      = 0;
    endfunction

    function int symbol_for(logic [CharW-1:0] c);
      if (c >= CharZero && c <= CharNine) return int'(c - CharZero);
      if (c >= CharLowA && c <= CharLowZ) return int'(c - CharLowA) + int'(SymLetter);
      if (c == CharDot) return int'(SymDot);
      return NoSym;
    endfunction

    function void settle(status_e st);
      decided     = 1'b1;
      held_status = st;
    endfunction

    function void step_to(int child);
      node = child;
      if (depth < int'(DepthMax)) depth++;
    endfunction

    // Follow or allocate the edge for one character
    function void walk_symbol(bit is_match, logic [CharW-1:0] c);
      int sym;
      int slot;
      sym = symbol_for(c);
      if (sym == NoSym) begin
        settle(StBadChar);
        return;
      end
      slot = node * AlphabetSize + sym;
      if (kids[slot] != '0) begin
        step_to(int'(kids[slot]));
        return;
      end
      if (is_match) begin
        settle(StNoMatch);
        return;
      end
      if (nodes_used >= NodeCapacity) begin
        settle(StFull);
        return;
      end
      for (int k = 0; k < AlphabetSize; k++) kids[nodes_used * AlphabetSize + k] = '0;
      marks[nodes_used] = 1'b0;
      kids[slot]        = NodeW'(nodes_used);
      nodes_used++;
      step_to(nodes_used - 1);
    endfunction

    // Note one accepted input beat; a last beat owes one result
    function void take_beat(bit is_match, logic [CharW-1:0] c, bit has, bit last);
      status_e st;
      res_t    r;
      if (!decided && is_match && marks[node]) settle(StMatch);
      if (!decided && has) begin
        walk_symbol(is_match, c);
        if (!decided && is_match && marks[node]) settle(StMatch);
      end
      if (!last) return;
      if (decided) begin
        st = held_status;
      end else if (is_match) begin
        st = StNoMatch;
      end else begin
        marks[node] = 1'b1;
        if (rules != RuleMax) rules++;
        st = StInserted;
      end
      r.status       = st;
      r.match_length = (st == StMatch) ? DepthW'(depth) : '0;
      r.rule_count   = rules;
      due_results.push_back(r);
      node        = 0;
      depth       = 0;
      decided     = 1'b0;
      held_status = StMatch;
    endfunction

    function void flag(string what, int want, int got);
      faults++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Compare one accepted result beat with the oldest owed result
    function void check_result(logic [2:0] st, logic [DepthW-1:0] len, logic [RuleW-1:0] cnt);
      res_t want;
      if (due_results.size() == 0) begin
        faults++;
        $display("%0t: unexpected result beat, expected none, actual status %0d length %0d count %0d",
                 $time, st, len, cnt);
        return;
      end
      want = due_results.pop_front();
      if (st !== want.status) flag("status", int'(want.status), int'(st));
      if (len !== want.match_length) flag("match_length", int'(want.match_length), int'(len));
      if (cnt !== want.rule_count) flag("rule_count", int'(want.rule_count), int'(cnt));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tpm_in_if  in_if ();
  tpm_out_if out_if ();

  trie_prefix_matcher_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  trie_tracker sb;
  int          beats_sent = 0;
  bit          calm       = 1'b0;
  string       rules_seen [$];

  always #5 clk_i = ~clk_i;

  // Random valid character; leading characters avoid the dot so it stays free
  function automatic logic [CharW-1:0] pick_char(bit no_dot);
    int r;
    r = no_dot ? $urandom_range(35) : $urandom_range(36);
    if (r < 10) return CharZero + CharW'(r);
    if (r < 36) return CharLowA + CharW'(r - 10);
    return CharDot;
  endfunction

  // Mostly bytes outside the supported ranges: their edges, 0x00 and 0xff
  function automatic logic [CharW-1:0] bad_char();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return CharZero - 8'd1;
      3:       return CharNine + 8'd1;
      4:       return CharLowA - 8'd1;
      5:       return CharLowZ + 8'd1;
      default: return CharW'($urandom_range(255));
    endcase
  endfunction

  function automatic string fresh_text(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, pick_char(i == 0));
    return s;
  endfunction

  // Present one beat, idling at random, and hold it until accepted
  task automatic send_beat(bit is_match, logic [CharW-1:0] c, bit has, bit last);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= is_match;
    in_if.ch        <= c;
    in_if.has_char  <= has;
    in_if.last_char <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.take_beat(is_match, c, has, last);
    beats_sent++;
    calm = (beats_sent >= 250 && beats_sent < 600);
  endtask

  task automatic send_text(bit is_match, string s);
    if (s.len() == 0) begin
      send_beat(is_match, CharW'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < s.len(); i++) send_beat(is_match, s[i], 1'b1, i == s.len() - 1);
    end
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.due_results.size() != 0);
  endtask

  // Broken strings: gaps, bad bytes and mixed commands
  task automatic send_noise();
    int               n;
    bit               seen_char;
    bit               has;
    bit               is_match;
    logic [CharW-1:0] c;
    n         = $urandom_range(8, 1);
    seen_char = 1'b0;
    for (int i = 0; i < n; i++) begin
      has      = $urandom_range(9) < 8;
      c        = ($urandom_range(9) < 7) ? pick_char(!seen_char) : bad_char();
      is_match = 1'($urandom_range(1));
      if (has && !seen_char && c == CharDot) c = CharLowA;
      if (has) seen_char = 1'b1;
      // an empty insert would mark the root, so keep it for the end
      if (i == n - 1 && !seen_char) is_match = CmdMatch;
      send_beat(is_match, c, has, i == n - 1);
    end
  endtask

  task automatic random_strings(int upto);
    int    pick;
    string s;
    while (beats_sent < upto) begin
      if ($urandom_range(99) < 4) drain_results();
      pick = $urandom_range(99);
      if (pick < 40) begin
        s = fresh_text($urandom_range(10, 1));
        send_text(CmdInsert, s);
        rules_seen.push_back(s);
      end else if (pick < 75 && rules_seen.size() != 0) begin
        s = rules_seen[$urandom_range(rules_seen.size() - 1)];
        case ($urandom_range(3))
          0:       s = s.substr(0, $urandom_range(s.len() - 1));
          1:       s = $sformatf("%s%s", s, fresh_text($urandom_range(4, 1)));
          2:       s = $sformatf("%s%c", s, bad_char());
          default: ;
        endcase
        send_text(CmdMatch, s);
      end else if (pick < 85) begin
        send_text(CmdMatch, fresh_text($urandom_range(6, 1)));
      end else begin
        send_noise();
      end
    end
  endtask

  // Result sink: random back-pressure, check each accepted beat
  initial begin : result_sink
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.status, out_if.match_length, out_if.rule_count);
      out_if.ready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  initial begin : stimulus
    int    free_nodes;
    string chain;
    sb = new();
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.cmd       <= 1'b0;
    in_if.ch        <= '0;
    in_if.has_char  <= 1'b0;
    in_if.last_char <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty string, symbol extremes, shortest prefix, bad byte, gap, mixed cmd
    send_text(CmdMatch, "");
    send_text(CmdInsert, "0");
    send_text(CmdInsert, "z9.");
    rules_seen.push_back("0");
    rules_seen.push_back("z9.");
    send_text(CmdMatch, "0abc");
    send_text(CmdMatch, "z9");
    send_text(CmdMatch, "z9.a");
    send_beat(CmdInsert, CharLowA, 1'b1, 1'b0);
    send_beat(CmdInsert, 8'hff, 1'b1, 1'b1);
    send_beat(CmdMatch, CharLowZ, 1'b1, 1'b0);
    send_beat(CmdMatch, 8'h00, 1'b0, 1'b0);
    send_beat(CmdMatch, CharNine, 1'b1, 1'b0);
    send_beat(CmdMatch, CharDot, 1'b1, 1'b1);
    send_text(CmdMatch, "q");
    send_beat(CmdInsert, CharLowA, 1'b1, 1'b0);
    send_beat(CmdMatch, CharLowA + 8'd1, 1'b1, 1'b1);

    random_strings(300);

    // Fill the node table with one long chain under the dot, then overflow it
    drain_results();
    free_nodes = NodeCapacity - sb.nodes_used;
    if (free_nodes > 0) begin
      chain = $sformatf("%c", CharDot);
      repeat (free_nodes - 1) chain = $sformatf("%s%c", chain, pick_char(1'b1));
      send_text(CmdInsert, chain);
      send_text(CmdMatch, $sformatf("%c%c", CharDot, CharDot));
      send_text(CmdInsert, $sformatf("%c%c", CharDot, CharDot));
    end

    random_strings(beats_sent + 200);

    // Mark the root and match through it
    drain_results();
    send_text(CmdInsert, "");
    send_text(CmdMatch, "abc");
    send_text(CmdMatch, "");
    repeat (3) send_text(CmdInsert, "");
    send_text(CmdMatch, "7");

    drain_results();
    repeat (EndSettle) @(posedge clk_i);
    if (sb.faults == 0) begin
      $display("trie_prefix_matcher_core_test passed");
    end else begin
      $display("trie_prefix_matcher_core_test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #40_000_000;
    $display("trie_prefix_matcher_core_test failed");
    $finish;
  end

endmodule
